// ===== src/swd_pkg.sv =====
package swd_pkg;

  // Backoff product: 32-bit step times 8-bit count
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned PROD_W  = TIME_W + CNT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Event codes
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_REQ_SENT = 3'd1;
  localparam logic [2:0] OP_RESPONSE = 3'd2;
  localparam logic [2:0] OP_VALUE    = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_REQUEST_TIMEOUT = 3'd0;
  localparam logic [2:0] CFG_MAX_UNANSWERED  = 3'd1;
  localparam logic [2:0] CFG_STALE_TIMEOUT   = 3'd2;
  localparam logic [2:0] CFG_BACKOFF_STEP    = 3'd3;
  localparam logic [2:0] CFG_BACKOFF_CAP     = 3'd4;

  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_PENDING    = 3'd1,
    MODE_SUBSCRIBED = 3'd2,
    MODE_STALE      = 3'd3,
    MODE_RESYNCING  = 3'd4,
    MODE_FAILED     = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ACT_NONE           = 2'd0,
    ACT_REQUEST        = 2'd1,
    ACT_STATUS_REQUEST = 2'd2
  } act_t;

  typedef struct packed {
    logic [TIME_W-1:0] request_timeout;
    logic [CNT_W-1:0]  max_unanswered;
    logic [TIME_W-1:0] stale_timeout;
    logic [TIME_W-1:0] backoff_step;
    logic [TIME_W-1:0] backoff_cap;
  } swd_cfg_t;

  // Watchdog state; backoff_prod tracks backoff_step * unanswered
  typedef struct packed {
    mode_t             mode;
    logic [TIME_W-1:0] sent_time;
    logic              sent_valid;
    logic [TIME_W-1:0] value_time;
    logic              value_valid;
    logic [TIME_W-1:0] resync_time;
    logic              resync_valid;
    logic [CNT_W-1:0]  unanswered;
    logic              refused;
    logic [PROD_W-1:0] backoff_prod;
  } swd_state_t;

  localparam swd_state_t STATE_CLEAR = '{
    mode:         MODE_IDLE,
    sent_time:    '0,
    sent_valid:   1'b0,
    value_time:   '0,
    value_valid:  1'b0,
    resync_time:  '0,
    resync_valid: 1'b0,
    unanswered:   '0,
    refused:      1'b0,
    backoff_prod: '0
  };

  localparam swd_cfg_t CFG_RESET = '{
    request_timeout: 32'd1000,
    max_unanswered:  8'd3,
    stale_timeout:   32'd2000,
    backoff_step:    32'd500,
    backoff_cap:     32'd5000
  };

endpackage

// ===== src/swd_step.sv =====
module swd_step (
  input  swd_pkg::swd_state_t  cur,
  input  swd_pkg::swd_cfg_t    cfg,
  input  logic [2:0]           op,
  input  logic [31:0]          now,
  input  logic                 accepted,
  output swd_pkg::swd_state_t  nxt,
  output swd_pkg::act_t        action
);
  import swd_pkg::*;

  logic [TIME_W-1:0] sent_elapsed;
  logic [TIME_W-1:0] value_elapsed;
  logic [TIME_W-1:0] resync_elapsed;
  logic [CNT_W-1:0]  unans_inc;
  logic [PROD_W-1:0] prod_inc;
  logic              under_backoff;

  // Modular elapsed times
  assign sent_elapsed   = now - cur.sent_time;
  assign value_elapsed  = now - cur.value_time;
  assign resync_elapsed = now - cur.resync_time;

  // Saturating count and its matching backoff product
  assign unans_inc = (cur.unanswered == CNT_MAX) ? cur.unanswered : cur.unanswered + 1'b1;
  assign prod_inc  = (cur.unanswered == CNT_MAX) ? cur.backoff_prod
                   : cur.backoff_prod + {{CNT_W{1'b0}}, cfg.backoff_step};

  // elapsed < min(product, cap)
  assign under_backoff = ({{CNT_W{1'b0}}, resync_elapsed} < cur.backoff_prod) &&
                         (resync_elapsed < cfg.backoff_cap);

  always_comb begin
    nxt    = cur;
    action = ACT_NONE;
    case (op)
      OP_TICK: begin
        unique case (cur.mode)
          MODE_IDLE: begin
            nxt.mode       = MODE_PENDING;
            nxt.sent_time  = now;
            nxt.sent_valid = 1'b1;
            action         = ACT_REQUEST;
          end
          MODE_PENDING: begin
            if (cur.sent_valid && sent_elapsed >= cfg.request_timeout) begin
              nxt.unanswered   = unans_inc;
              nxt.backoff_prod = prod_inc;
              nxt.mode         = (unans_inc >= cfg.max_unanswered) ? MODE_FAILED
                                                                   : MODE_RESYNCING;
              nxt.resync_time  = now;
              nxt.resync_valid = 1'b1;
            end
          end
          MODE_SUBSCRIBED: begin
            if (cur.value_valid && value_elapsed >= cfg.stale_timeout) begin
              nxt.mode = MODE_STALE;
            end
          end
          MODE_STALE: begin
            nxt.mode         = MODE_PENDING;
            nxt.sent_time    = now;
            nxt.sent_valid   = 1'b1;
            nxt.resync_time  = now;
            nxt.resync_valid = 1'b1;
            action           = ACT_STATUS_REQUEST;
          end
          MODE_RESYNCING: begin
            if (cur.resync_valid && !under_backoff) begin
              nxt.mode         = MODE_PENDING;
              nxt.sent_time    = now;
              nxt.sent_valid   = 1'b1;
              nxt.resync_time  = now;
              nxt.resync_valid = 1'b1;
              action           = ACT_REQUEST;
            end
          end
          MODE_FAILED: begin
            if (!cur.resync_valid || resync_elapsed >= cfg.backoff_cap) begin
              nxt.sent_time    = now;
              nxt.sent_valid   = 1'b1;
              nxt.resync_time  = now;
              nxt.resync_valid = 1'b1;
              action           = ACT_REQUEST;
            end
          end
          default: begin
            nxt = cur;
          end
        endcase
      end
      OP_REQ_SENT: begin
        nxt.sent_time  = now;
        nxt.sent_valid = 1'b1;
        if (cur.mode == MODE_IDLE || cur.mode == MODE_STALE ||
            cur.mode == MODE_RESYNCING) begin
          nxt.mode = MODE_PENDING;
        end
      end
      OP_RESPONSE: begin
        nxt.unanswered   = '0;
        nxt.backoff_prod = '0;
        nxt.refused      = !accepted;
        if (accepted) begin
          nxt.mode        = MODE_SUBSCRIBED;
          nxt.value_time  = now;
          nxt.value_valid = 1'b1;
        end else begin
          nxt.mode         = MODE_RESYNCING;
          nxt.resync_time  = now;
          nxt.resync_valid = 1'b1;
        end
      end
      OP_VALUE: begin
        nxt.value_time   = now;
        nxt.value_valid  = 1'b1;
        nxt.unanswered   = '0;
        nxt.backoff_prod = '0;
        nxt.mode         = MODE_SUBSCRIBED;
      end
      OP_CLEAR: begin
        nxt = STATE_CLEAR;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// ===== src/subscription_watchdog_fsm_core.sv =====
// Subscription watchdog core.
// Input channel: in_op, in_now, in_accepted with in_valid / in_stall. Each
// transfer is one event (tick, request sent, response, value, clear) stamped
// with a wrapping tick time.
// Output channel: out_action, out_mode_now, out_unanswered_now,
// out_refused_flag with out_valid / out_stall. Every event yields exactly one
// result: the action to take and a snapshot of the state after the event.
// An event passes the input register, then the state update lands in the
// result register. One event per cycle is sustained while out_stall is
// low; the update is a single pass of compares and one 40-bit backoff add.
// When the receiver stalls, the result register holds and one more event can
// wait in the input register; in_stall rises only when both are full.
// Configuration: cfg_we, cfg_index, cfg_data write a register.
// Write only while no event is in flight. A backoff_step write refreshes the
// stored backoff product with one multiply in that cycle.
// Reset (rst_n low, synchronous) empties both registers, sets mode idle,
// invalidates all stamps and loads the register defaults.
module subscription_watchdog_fsm_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_now,
  input  logic        in_accepted,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_action,
  output logic [2:0]  out_mode_now,
  output logic [7:0]  out_unanswered_now,
  output logic        out_refused_flag,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import swd_pkg::*;

  swd_cfg_t          cfg_r;
  swd_state_t        state_r;
  swd_state_t        state_nxt;
  act_t              action_nxt;

  logic              s1_valid_r;
  logic [2:0]        s1_op_r;
  logic [TIME_W-1:0] s1_now_r;
  logic              s1_acc_r;

  logic              out_valid_r;
  logic [1:0]        out_action_r;
  logic [2:0]        out_mode_r;
  logic [CNT_W-1:0]  out_unans_r;
  logic              out_refused_r;

  logic              in_fire;
  logic              s1_adv;
  logic [PROD_W-1:0] prod_cfg;

  // Handshake
  assign s1_adv   = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // Backoff product for a new step value
  assign prod_cfg = {{CNT_W{1'b0}}, cfg_data} * {{TIME_W{1'b0}}, state_r.unanswered};

  swd_step u_step (
    .cur      (state_r),
    .cfg      (cfg_r),
    .op       (s1_op_r),
    .now      (s1_now_r),
    .accepted (s1_acc_r),
    .nxt      (state_nxt),
    .action   (action_nxt)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REQUEST_TIMEOUT: cfg_r.request_timeout <= cfg_data;
        CFG_MAX_UNANSWERED:  cfg_r.max_unanswered  <= cfg_data[CNT_W-1:0];
        CFG_STALE_TIMEOUT:   cfg_r.stale_timeout   <= cfg_data;
        CFG_BACKOFF_STEP:    cfg_r.backoff_step    <= cfg_data;
        CFG_BACKOFF_CAP:     cfg_r.backoff_cap     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Watchdog state: advance on each event, refresh product on step write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_CLEAR;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end else if (cfg_we && cfg_index == CFG_BACKOFF_STEP) begin
      state_r.backoff_prod <= prod_cfg;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r  <= in_op;
      s1_now_r <= in_now;
      s1_acc_r <= in_accepted;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_action_r  <= action_nxt;
      out_mode_r    <= state_nxt.mode;
      out_unans_r   <= state_nxt.unanswered;
      out_refused_r <= state_nxt.refused;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = out_action_r;
  assign out_mode_now       = out_mode_r;
  assign out_unanswered_now = out_unans_r;
  assign out_refused_flag   = out_refused_r;

endmodule

// ===== tb/sv/swd_status_checker.sv =====
module swd_status_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_now,
  input  logic        in_accepted,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_action,
  input  logic [2:0]  out_mode_now,
  input  logic [7:0]  out_unanswered_now,
  input  logic        out_refused_flag,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_cnt,
  output int          open_cnt
);
  import swd_pkg::*;

  typedef struct packed {
    act_t       action;
    mode_t      mode;
    logic [7:0] unanswered;
    logic       refused;
  } status_t;

  // Shadow copy of the configuration registers
  logic [31:0] wd_req_to;
  logic [7:0]  wd_max_unans;
  logic [31:0] wd_stale_to;
  logic [31:0] wd_step;
  logic [31:0] wd_cap;

  // Shadow copy of the watchdog state
  mode_t       wd_mode;
  logic [31:0] wd_sent_time;
  logic        wd_sent_valid;
  logic [31:0] wd_value_time;
  logic        wd_value_valid;
  logic [31:0] wd_resync_time;
  logic        wd_resync_valid;
  logic [7:0]  wd_unans;
  logic        wd_refused;

  // Status words still owed by the block, oldest first
  status_t predicted_status [$];

  function automatic void clear_watchdog();
    wd_mode         = MODE_IDLE;
    wd_sent_time    = '0;
    wd_sent_valid   = 1'b0;
    wd_value_time   = '0;
    wd_value_valid  = 1'b0;
    wd_resync_time  = '0;
    wd_resync_valid = 1'b0;
    wd_unans        = '0;
    wd_refused      = 1'b0;
  endfunction

  function automatic void stamp_request(input logic [31:0] now);
    wd_sent_time  = now;
    wd_sent_valid = 1'b1;
  endfunction

  function automatic void stamp_resync(input logic [31:0] now);
    wd_resync_time  = now;
    wd_resync_valid = 1'b1;
  endfunction

  // Apply one event to the shadow state and return the status it yields
  function automatic status_t step_watchdog(input logic [2:0] op, input logic [31:0] now,
                                            input logic acc);
    status_t     res;
    act_t        act;
    logic [31:0] since_sent;
    logic [31:0] since_value;
    logic [31:0] since_resync;
    logic [39:0] backoff;
    act          = ACT_NONE;
    since_sent   = now - wd_sent_time;
    since_value  = now - wd_value_time;
    since_resync = now - wd_resync_time;
    case (op)
      OP_TICK: begin
        case (wd_mode)
          MODE_IDLE: begin
            wd_mode = MODE_PENDING;
            stamp_request(now);
            act = ACT_REQUEST;
          end
          MODE_PENDING: begin
            if (wd_sent_valid && since_sent >= wd_req_to) begin
              if (wd_unans != 8'hFF) wd_unans = wd_unans + 8'd1;
              if (wd_unans >= wd_max_unans) wd_mode = MODE_FAILED;
              else wd_mode = MODE_RESYNCING;
              stamp_resync(now);
            end
          end
          MODE_SUBSCRIBED: begin
            if (wd_value_valid && since_value >= wd_stale_to) wd_mode = MODE_STALE;
          end
          MODE_STALE: begin
            wd_mode = MODE_PENDING;
            stamp_request(now);
            stamp_resync(now);
            act = ACT_STATUS_REQUEST;
          end
          MODE_RESYNCING: begin
            // Linear backoff, capped; the product needs 40 bits
            backoff = {8'd0, wd_step} * {32'd0, wd_unans};
            if (backoff > {8'd0, wd_cap}) backoff = {8'd0, wd_cap};
            if (wd_resync_valid && {8'd0, since_resync} >= backoff) begin
              wd_mode = MODE_PENDING;
              stamp_request(now);
              stamp_resync(now);
              act = ACT_REQUEST;
            end
          end
          MODE_FAILED: begin
            // Slow probe every backoff_cap ticks
            if (!wd_resync_valid || since_resync >= wd_cap) begin
              stamp_request(now);
              stamp_resync(now);
              act = ACT_REQUEST;
            end
          end
          default: ;
        endcase
      end
      OP_REQ_SENT: begin
        stamp_request(now);
        if (wd_mode == MODE_IDLE || wd_mode == MODE_STALE || wd_mode == MODE_RESYNCING)
          wd_mode = MODE_PENDING;
      end
      OP_RESPONSE: begin
        wd_unans   = '0;
        wd_refused = !acc;
        if (acc) begin
          wd_mode        = MODE_SUBSCRIBED;
          wd_value_time  = now;
          wd_value_valid = 1'b1;
        end else begin
          wd_mode = MODE_RESYNCING;
          stamp_resync(now);
        end
      end
      OP_VALUE: begin
        wd_value_time  = now;
        wd_value_valid = 1'b1;
        wd_unans       = '0;
        wd_mode        = MODE_SUBSCRIBED;
      end
      OP_CLEAR: clear_watchdog();
      default: ;
    endcase
    res.action     = act;
    res.mode       = wd_mode;
    res.unanswered = wd_unans;
    res.refused    = wd_refused;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      fail_cnt++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Track config writes, predict on input transfers, compare on result transfers
  always @(posedge clk) begin : track_p
    status_t want;
    if (!rst_n) begin
      wd_req_to    = CFG_RESET.request_timeout;
      wd_max_unans = CFG_RESET.max_unanswered;
      wd_stale_to  = CFG_RESET.stale_timeout;
      wd_step      = CFG_RESET.backoff_step;
      wd_cap       = CFG_RESET.backoff_cap;
      clear_watchdog();
      predicted_status.delete();
      fail_cnt = 0;
      open_cnt <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REQUEST_TIMEOUT: wd_req_to    = cfg_data;
          CFG_MAX_UNANSWERED:  wd_max_unans = cfg_data[7:0];
          CFG_STALE_TIMEOUT:   wd_stale_to  = cfg_data;
          CFG_BACKOFF_STEP:    wd_step      = cfg_data;
          CFG_BACKOFF_CAP:     wd_cap       = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predicted_status.push_back(step_watchdog(in_op, in_now, in_accepted));
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (predicted_status.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result: action %0d mode %0d unanswered %0d refused %0d",
                   $time, out_action, out_mode_now, out_unanswered_now, out_refused_flag);
        end else begin
          want = predicted_status.pop_front();
          check_field("action", 8'(want.action), 8'(out_action));
          check_field("mode_now", 8'(want.mode), 8'(out_mode_now));
          check_field("unanswered_now", want.unanswered, out_unanswered_now);
          check_field("refused_flag", 8'(want.refused), 8'(out_refused_flag));
        end
      end
      open_cnt <= predicted_status.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import swd_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;

  // Op codes the block ignores
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op = OP_TICK;
  logic [31:0] in_now = '0;
  logic        in_accepted = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_action;
  logic [2:0]  out_mode_now;
  logic [7:0]  out_unanswered_now;
  logic        out_refused_flag;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_REQUEST_TIMEOUT;
  logic [31:0] cfg_data = '0;
  int          fail_cnt;
  int          open_cnt;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] t_now = '0;

  // Current register values, used to aim time steps at the thresholds
  logic [31:0] cur_req_to = CFG_RESET.request_timeout;
  logic [31:0] cur_stale  = CFG_RESET.stale_timeout;
  logic [31:0] cur_step   = CFG_RESET.backoff_step;
  logic [31:0] cur_cap    = CFG_RESET.backoff_cap;

  subscription_watchdog_fsm_core u_dut (.*);

  swd_status_checker u_checker (.*);

  always #5 clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Abort when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_event(input logic [2:0] op, input logic [31:0] now, input logic acc);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_now      <= now;
    in_accepted <= acc;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off the sender until every status has come back
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_cnt != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [31:0] req_to, input logic [7:0] max_un,
                               input logic [31:0] stale_to, input logic [31:0] step,
                               input logic [31:0] cap);
    put_reg(CFG_REQUEST_TIMEOUT, req_to);
    put_reg(CFG_MAX_UNANSWERED, {24'd0, max_un});
    put_reg(CFG_STALE_TIMEOUT, stale_to);
    put_reg(CFG_BACKOFF_STEP, step);
    put_reg(CFG_BACKOFF_CAP, cap);
    cfg_we     <= 1'b0;
    cur_req_to = req_to;
    cur_stale  = stale_to;
    cur_step   = step;
    cur_cap    = cap;
  endtask

  // Pick a time advance: zero, tiny, around a threshold, or anything
  function automatic logic [31:0] pick_step();
    logic [31:0] lim;
    case ($urandom_range(7))
      0: return 32'd0;
      1, 2: return $urandom_range(8);
      3: lim = cur_req_to;
      4: lim = cur_stale;
      5: lim = cur_step;
      6: lim = cur_cap;
      default: return $urandom();
    endcase
    case ($urandom_range(3))
      0: return lim;
      1: return lim - 32'd1;
      default: return $urandom_range(lim);
    endcase
  endfunction

  // Episodes: silent tick runs, healthy traffic, mixed events, noise
  task automatic run_phase(input int unsigned budget, input bit ticks_only);
    int unsigned done_n;
    int unsigned kind;
    int unsigned r;
    logic [2:0]  op;
    logic        acc;
    done_n = 0;
    while (done_n < budget) begin
      if ($urandom_range(24) == 0) wait_results_done();
      kind = ticks_only ? 0 : $urandom_range(9);
      repeat ($urandom_range(24, 4)) begin
        r   = $urandom_range(99);
        acc = ($urandom_range(4) != 0);
        t_now = t_now + pick_step();
        if (kind < 4) begin
          op = (r < 90) ? OP_TICK : OP_REQ_SENT;
        end else if (kind < 7) begin
          if (r < 50) op = OP_TICK;
          else if (r < 75) op = OP_VALUE;
          else if (r < 90) op = OP_RESPONSE;
          else op = OP_REQ_SENT;
        end else if (kind < 9) begin
          op  = 3'($urandom_range(OP_CLEAR));
          acc = 1'($urandom_range(1));
        end else begin
          op  = 3'($urandom_range(OP_SPARE_7));
          acc = 1'($urandom_range(1));
          if (r < 30) t_now = $urandom();
        end
        if (ticks_only) op = OP_TICK;
        send_event(op, t_now, acc);
        if (op <= OP_CLEAR) done_n++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk through every mode under the default registers
    send_event(OP_SPARE_5, 32'd0, 1'b0);
    send_event(OP_SPARE_7, 32'hFFFF_FFFF, 1'b1);
    send_event(OP_TICK, 32'd0, 1'b0);
    send_event(OP_TICK, 32'd999, 1'b0);
    send_event(OP_TICK, 32'd1000, 1'b0);
    send_event(OP_TICK, 32'd1499, 1'b0);
    send_event(OP_TICK, 32'd1500, 1'b0);
    send_event(OP_TICK, 32'd2500, 1'b0);
    send_event(OP_TICK, 32'd3500, 1'b0);
    send_event(OP_TICK, 32'd4500, 1'b0);
    send_event(OP_TICK, 32'd9499, 1'b0);
    send_event(OP_TICK, 32'd9500, 1'b0);
    send_event(OP_REQ_SENT, 32'hFFFF_FFF0, 1'b0);
    send_event(OP_RESPONSE, 32'd10, 1'b0);
    send_event(OP_REQ_SENT, 32'd20, 1'b0);
    send_event(OP_TICK, 32'd1020, 1'b0);
    send_event(OP_RESPONSE, 32'hFFFF_FC00, 1'b1);
    send_event(OP_TICK, 32'h0000_03CF, 1'b0);
    send_event(OP_TICK, 32'h0000_03D0, 1'b0);
    send_event(OP_TICK, 32'h0000_03D1, 1'b0);
    send_event(OP_VALUE, 32'h0000_4000, 1'b0);
    send_event(OP_SPARE_6, 32'h5555_AAAA, 1'b1);
    send_event(OP_CLEAR, 32'd0, 1'b0);
    send_event(OP_VALUE, 32'd0, 1'b0);
    send_event(OP_CLEAR, 32'hFFFF_FFFF, 1'b1);
    t_now = 32'h0000_5000;

    // Random phases; phases 1 to 7 load a register setting, and each phase uses one of four idle and stall patterns
    for (int ph = 0; ph < 8; ph++) begin
      wait_results_done();
      case (ph)
        1: load_settings(32'd20, 8'd3, 32'd40, 32'd10, 32'd50);
        2: load_settings(32'd0, 8'd1, 32'd0, 32'd0, 32'd0);
        3: load_settings('1, 8'hFF, '1, '1, '1);
        4: load_settings(32'd25, 8'd0, 32'd50, 32'd7, 32'd90);
        5: load_settings(32'd30, 8'd6, 32'd60, 32'hC000_0000, 32'hFFFF_FFF0);
        6: load_settings(32'd0, 8'hFF, 32'd0, 32'd0, 32'd3);
        7: load_settings($urandom_range(300), 8'($urandom_range(8, 1)),
                         $urandom_range(300), $urandom_range(100), $urandom_range(400));
        default: ;
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      case (ph)
        0: run_phase(150, 1'b0);
        1: run_phase(170, 1'b0);
        5: run_phase(120, 1'b0);
        6: begin
          // Climb the unanswered count all the way to saturation
          send_event(OP_CLEAR, t_now, 1'b0);
          run_phase(520, 1'b1);
        end
        7: run_phase(120, 1'b0);
        default: run_phase(100, 1'b0);
      endcase
    end

    wait_results_done();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
